FILE: rtl/lgpc_pkg.sv
// ----------------------------------------------------------------------------
// lgpc_pkg: shared types and constants of the linear gradient pixel color block
// Frame size, fixed-point widths, reciprocal constants for the position
// divide and the codes of the fill modes and configuration registers.
// ----------------------------------------------------------------------------
package lgpc_pkg;

	// integer square root, only evaluated at elaboration
	function automatic longint unsigned isqrt(input longint unsigned n);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned bitv;
		rem  = n;
		res  = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// frame size
	localparam int unsigned WIDTH  = 320;
	localparam int unsigned HEIGHT = 240;

	// port widths
	localparam int unsigned PX_W       = 9;
	localparam int unsigned PY_W       = 8;
	localparam int unsigned COLOR_W    = 16;
	localparam int unsigned DIR_W      = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// position t, unsigned Q0.16 with one extra bit for 1.0
	localparam int unsigned T_FRAC = 16;
	localparam int unsigned T_W    = T_FRAC + 1;
	localparam int unsigned T_ONE  = 1 << T_FRAC;
	localparam int unsigned T_HALF = 1 << (T_FRAC - 1);

	// projection products and sum (signed)
	localparam int unsigned PDX_W  = PX_W + 1 + DIR_W;
	localparam int unsigned PDY_W  = PY_W + 1 + DIR_W;
	localparam int unsigned PROJ_W = PDX_W + 1;

	// numerator scaling: vertical/horizontal use 2^16, diagonal 2^10 (Q.14 over Q.8)
	localparam int unsigned P_VH = 16;
	localparam int unsigned P_D  = 10;

	// diagonal length in Q.8
	localparam longint unsigned DIAG =
		isqrt((longint'(WIDTH) * WIDTH + longint'(HEIGHT) * HEIGHT) << 16);

	// smallest operand value that makes t reach 1.0 in each mode
	localparam longint unsigned LIM_V = HEIGHT;
	localparam longint unsigned LIM_H = WIDTH;
	localparam longint unsigned LIM_D = DIAG << (P_VH - P_D);

	// reciprocal shifts and multipliers: q0 = (v * R) >> S, off by at most one
	localparam int unsigned S_V = $clog2(LIM_V);
	localparam int unsigned S_H = $clog2(LIM_H);
	localparam int unsigned S_D = $clog2(LIM_D);
	localparam longint unsigned R_V = (longint'(1) << (S_V + P_VH)) / HEIGHT;
	localparam longint unsigned R_H = (longint'(1) << (S_H + P_VH)) / WIDTH;
	localparam longint unsigned R_D = (longint'(1) << (S_D + P_D)) / DIAG;

	// datapath widths of the divide
	localparam int unsigned V_W    = S_D;
	localparam int unsigned R_W    = 17;
	localparam int unsigned PROD_W = V_W + R_W;
	localparam int unsigned SH_W   = $clog2(PROD_W);
	localparam int unsigned C_W    = $clog2(DIAG + 1);
	localparam int unsigned NUM_W  = (V_W + P_VH > T_W + C_W) ? V_W + P_VH : T_W + C_W;

	// color channel widths and interpolation product widths
	localparam int unsigned RB_W  = 5;
	localparam int unsigned G_W   = 6;
	localparam int unsigned MRB_W = T_W + 1 + RB_W + 1;
	localparam int unsigned MG_W  = T_W + 1 + G_W + 1;

	typedef enum logic [1:0] {
		MODE_SOLID = 2'd0,
		MODE_VERT  = 2'd1,
		MODE_HORIZ = 2'd2,
		MODE_DIAG  = 2'd3
	} fill_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILL_MODE   = 3'd0,
		REG_THREE_STOPS = 3'd1,
		REG_SOLID_COLOR = 3'd2,
		REG_STOP_0      = 3'd3,
		REG_STOP_1      = 3'd4,
		REG_STOP_2      = 3'd5,
		REG_DIR_X       = 3'd6,
		REG_DIR_Y       = 3'd7
	} cfg_reg_t;

	localparam logic signed [DIR_W-1:0] DIR_X_RESET = 16'sd16384;

endpackage

FILE: rtl/linear_gradient_pixel_color.sv
// ----------------------------------------------------------------------------
// linear_gradient_pixel_color: RGB565 background color of one pixel
// Six-stage pipeline: projection, position divide by reciprocal with one
// correction step, clamp, stop select and per-channel interpolation.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: pixel_x/pixel_y with in_valid, in_stall. A request is taken
//   at a rising edge with in_valid high and in_stall low.
//   Output channel: pixel_color with out_valid, out_stall, same rule.
//   Config port: cfg_we, cfg_index, cfg_data; a register is written at each
//   edge with cfg_we high. Write only while the pipeline is empty.
//   Throughput: one pixel per clock while out_stall is low; every
//   stage is a plain register and the slowest stage holds one 23x17
//   multiply (the reciprocal of the divide).
//   Stall: each stage advances when it is empty or the next one advances, so
//   bubbles close up; in_stall rises only when all six stages hold a pixel
//   and out_stall is high. Nothing is dropped or repeated.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (solid mode, black, direction along +x, two stops).
// ----------------------------------------------------------------------------
module linear_gradient_pixel_color (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lgpc_pkg::PX_W-1:0]             pixel_x,
	input  logic [lgpc_pkg::PY_W-1:0]             pixel_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [lgpc_pkg::COLOR_W-1:0]          pixel_color,
	input  logic                                  cfg_we,
	input  logic [lgpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lgpc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	// configuration registers
	lgpc_pkg::fill_mode_t                  fill_mode_q;
	logic                                  three_stops_q;
	logic [lgpc_pkg::COLOR_W-1:0]          solid_color_q;
	logic [lgpc_pkg::COLOR_W-1:0]          stop0_q;
	logic [lgpc_pkg::COLOR_W-1:0]          stop1_q;
	logic [lgpc_pkg::COLOR_W-1:0]          stop2_q;
	logic signed [lgpc_pkg::DIR_W-1:0]     dir_x_q;
	logic signed [lgpc_pkg::DIR_W-1:0]     dir_y_q;

	// stage valid bits and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv_1, adv_2, adv_3, adv_4, adv_5, adv_6;

	// stage 1
	logic [lgpc_pkg::PX_W-1:0]             px_s1;
	logic [lgpc_pkg::PY_W-1:0]             py_s1;
	logic signed [lgpc_pkg::PDX_W-1:0]     pdx_s1;
	logic signed [lgpc_pkg::PDY_W-1:0]     pdy_s1;
	// stage 2
	logic [lgpc_pkg::V_W-1:0]              v_s2;
	logic                                  sat_s2;
	logic                                  zero_s2;
	// stage 3
	logic [lgpc_pkg::V_W-1:0]              v_s3;
	logic [lgpc_pkg::T_W-1:0]              q0_s3;
	logic                                  sat_s3;
	logic                                  zero_s3;
	// stage 4
	logic [lgpc_pkg::T_W-1:0]              t_s4;
	// stage 5
	logic [lgpc_pkg::T_W-1:0]              tt_s5;
	logic [lgpc_pkg::RB_W-1:0]             ar_s5;
	logic [lgpc_pkg::G_W-1:0]              ag_s5;
	logic [lgpc_pkg::RB_W-1:0]             ab_s5;
	logic signed [lgpc_pkg::RB_W:0]        dr_s5;
	logic signed [lgpc_pkg::G_W:0]         dg_s5;
	logic signed [lgpc_pkg::RB_W:0]        db_s5;
	// stage 6
	logic [lgpc_pkg::COLOR_W-1:0]          color_s6;

	// combinational stage logic
	logic signed [lgpc_pkg::PROJ_W-1:0]    proj;
	logic [lgpc_pkg::V_W-1:0]              v_nx;
	logic                                  sat_nx;
	logic                                  zero_nx;
	logic [lgpc_pkg::PROD_W-1:0]           prod;
	logic [lgpc_pkg::R_W-1:0]              r_sel;
	logic [lgpc_pkg::SH_W-1:0]             sh_sel;
	logic [lgpc_pkg::C_W-1:0]              c_sel;
	logic [lgpc_pkg::NUM_W-1:0]            num;
	logic [lgpc_pkg::NUM_W-1:0]            chk;
	logic [lgpc_pkg::T_W-1:0]              t_nx;
	logic [lgpc_pkg::T_W-1:0]              tt_nx;
	logic [lgpc_pkg::COLOR_W-1:0]          lo_c;
	logic [lgpc_pkg::COLOR_W-1:0]          hi_c;
	logic signed [lgpc_pkg::MRB_W-1:0]     mr;
	logic signed [lgpc_pkg::MG_W-1:0]      mg;
	logic signed [lgpc_pkg::MRB_W-1:0]     mb;
	logic [lgpc_pkg::RB_W-1:0]             cr;
	logic [lgpc_pkg::G_W-1:0]              cg;
	logic [lgpc_pkg::RB_W-1:0]             cb;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q   <= lgpc_pkg::MODE_SOLID;
			three_stops_q <= 1'b0;
			solid_color_q <= '0;
			stop0_q       <= '0;
			stop1_q       <= '0;
			stop2_q       <= '0;
			dir_x_q       <= lgpc_pkg::DIR_X_RESET;
			dir_y_q       <= '0;
		end else if (cfg_we) begin
			unique case (lgpc_pkg::cfg_reg_t'(cfg_index))
				lgpc_pkg::REG_FILL_MODE:   fill_mode_q   <= lgpc_pkg::fill_mode_t'(cfg_data[1:0]);
				lgpc_pkg::REG_THREE_STOPS: three_stops_q <= cfg_data[0];
				lgpc_pkg::REG_SOLID_COLOR: solid_color_q <= cfg_data;
				lgpc_pkg::REG_STOP_0:      stop0_q       <= cfg_data;
				lgpc_pkg::REG_STOP_1:      stop1_q       <= cfg_data;
				lgpc_pkg::REG_STOP_2:      stop2_q       <= cfg_data;
				lgpc_pkg::REG_DIR_X:       dir_x_q       <= $signed(cfg_data);
				lgpc_pkg::REG_DIR_Y:       dir_y_q       <= $signed(cfg_data);
			endcase
		end
	end

	// a stage moves when it is empty or its successor moves
	assign adv_6     = !vld_s6 || !out_stall;
	assign adv_5     = !vld_s5 || adv_6;
	assign adv_4     = !vld_s4 || adv_5;
	assign adv_3     = !vld_s3 || adv_4;
	assign adv_2     = !vld_s2 || adv_3;
	assign adv_1     = !vld_s1 || adv_2;
	assign in_stall  = !adv_1;
	assign out_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_1) vld_s1 <= in_valid;
			if (adv_2) vld_s2 <= vld_s1;
			if (adv_3) vld_s3 <= vld_s2;
			if (adv_4) vld_s4 <= vld_s3;
			if (adv_5) vld_s5 <= vld_s4;
			if (adv_6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: projection products
	always_ff @(posedge clk) begin
		if (adv_1) begin
			px_s1  <= pixel_x;
			py_s1  <= pixel_y;
			pdx_s1 <= $signed({1'b0, pixel_x}) * dir_x_q;
			pdy_s1 <= $signed({1'b0, pixel_y}) * dir_y_q;
		end
	end

	// stage 2: operand select, saturation and non-positive detect
	always_comb begin
		proj    = lgpc_pkg::PROJ_W'(pdx_s1) + lgpc_pkg::PROJ_W'(pdy_s1);
		v_nx    = lgpc_pkg::V_W'(px_s1);
		sat_nx  = 1'b0;
		zero_nx = 1'b0;
		unique case (fill_mode_q)
			lgpc_pkg::MODE_VERT: begin
				v_nx   = lgpc_pkg::V_W'(py_s1);
				sat_nx = 32'(py_s1) >= lgpc_pkg::HEIGHT;
			end
			lgpc_pkg::MODE_DIAG: begin
				v_nx    = lgpc_pkg::V_W'($unsigned(proj));
				zero_nx = proj[lgpc_pkg::PROJ_W-1] || (proj == '0);
				sat_nx  = !zero_nx &&
					($unsigned(proj) >= lgpc_pkg::PROJ_W'(lgpc_pkg::LIM_D));
			end
			lgpc_pkg::MODE_HORIZ, lgpc_pkg::MODE_SOLID: begin
				v_nx   = lgpc_pkg::V_W'(px_s1);
				sat_nx = 32'(px_s1) >= lgpc_pkg::WIDTH;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_2) begin
			v_s2    <= v_nx;
			sat_s2  <= sat_nx;
			zero_s2 <= zero_nx;
		end
	end

	// stage 3: reciprocal multiply, quotient estimate
	always_comb begin
		unique case (fill_mode_q)
			lgpc_pkg::MODE_VERT: begin
				r_sel  = lgpc_pkg::R_W'(lgpc_pkg::R_V);
				sh_sel = lgpc_pkg::SH_W'(lgpc_pkg::S_V);
			end
			lgpc_pkg::MODE_DIAG: begin
				r_sel  = lgpc_pkg::R_W'(lgpc_pkg::R_D);
				sh_sel = lgpc_pkg::SH_W'(lgpc_pkg::S_D);
			end
			lgpc_pkg::MODE_HORIZ, lgpc_pkg::MODE_SOLID: begin
				r_sel  = lgpc_pkg::R_W'(lgpc_pkg::R_H);
				sh_sel = lgpc_pkg::SH_W'(lgpc_pkg::S_H);
			end
		endcase
		prod = lgpc_pkg::PROD_W'(v_s2) * lgpc_pkg::PROD_W'(r_sel);
	end

	always_ff @(posedge clk) begin
		if (adv_3) begin
			v_s3    <= v_s2;
			q0_s3   <= lgpc_pkg::T_W'(prod >> sh_sel);
			sat_s3  <= sat_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: one-step quotient correction and clamp
	always_comb begin
		unique case (fill_mode_q)
			lgpc_pkg::MODE_VERT: begin
				c_sel = lgpc_pkg::C_W'(lgpc_pkg::HEIGHT);
				num   = lgpc_pkg::NUM_W'(v_s3) << lgpc_pkg::P_VH;
			end
			lgpc_pkg::MODE_DIAG: begin
				c_sel = lgpc_pkg::C_W'(lgpc_pkg::DIAG);
				num   = lgpc_pkg::NUM_W'(v_s3) << lgpc_pkg::P_D;
			end
			lgpc_pkg::MODE_HORIZ, lgpc_pkg::MODE_SOLID: begin
				c_sel = lgpc_pkg::C_W'(lgpc_pkg::WIDTH);
				num   = lgpc_pkg::NUM_W'(v_s3) << lgpc_pkg::P_VH;
			end
		endcase
		chk = (lgpc_pkg::NUM_W'(q0_s3) + lgpc_pkg::NUM_W'(1)) * lgpc_pkg::NUM_W'(c_sel);
		priority if (sat_s3) begin
			t_nx = lgpc_pkg::T_W'(lgpc_pkg::T_ONE);
		end else if (zero_s3) begin
			t_nx = '0;
		end else begin
			t_nx = q0_s3 + lgpc_pkg::T_W'(num >= chk);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_4) t_s4 <= t_nx;
	end

	// stage 5: stop pair select and channel differences
	always_comb begin
		tt_nx = t_s4;
		lo_c  = stop0_q;
		hi_c  = stop1_q;
		if (three_stops_q) begin
			if (t_s4 < lgpc_pkg::T_W'(lgpc_pkg::T_HALF)) begin
				tt_nx = t_s4 << 1;
			end else begin
				tt_nx = (t_s4 - lgpc_pkg::T_W'(lgpc_pkg::T_HALF)) << 1;
				lo_c  = stop1_q;
				hi_c  = stop2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_5) begin
			tt_s5 <= tt_nx;
			ar_s5 <= lo_c[15:11];
			ag_s5 <= lo_c[10:5];
			ab_s5 <= lo_c[4:0];
			dr_s5 <= $signed({1'b0, hi_c[15:11]}) - $signed({1'b0, lo_c[15:11]});
			dg_s5 <= $signed({1'b0, hi_c[10:5]}) - $signed({1'b0, lo_c[10:5]});
			db_s5 <= $signed({1'b0, hi_c[4:0]}) - $signed({1'b0, lo_c[4:0]});
		end
	end

	// stage 6: start + floor(t * diff) within the stop range, or the solid color
	always_comb begin
		mr = $signed({1'b0, tt_s5}) * dr_s5;
		mg = $signed({1'b0, tt_s5}) * dg_s5;
		mb = $signed({1'b0, tt_s5}) * db_s5;
		cr = ar_s5 + lgpc_pkg::RB_W'(mr >>> lgpc_pkg::T_FRAC);
		cg = ag_s5 + lgpc_pkg::G_W'(mg >>> lgpc_pkg::T_FRAC);
		cb = ab_s5 + lgpc_pkg::RB_W'(mb >>> lgpc_pkg::T_FRAC);
	end

	always_ff @(posedge clk) begin
		if (adv_6) begin
			if (fill_mode_q == lgpc_pkg::MODE_SOLID) begin
				color_s6 <= solid_color_q;
			end else begin
				color_s6 <= {cr, cg, cb};
			end
		end
	end

	assign pixel_color = color_s6;

	// back-pressure only reaches the input with a full pipeline
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && out_stall))
		else $error("input stalled with room in the pipeline");

	// an accepted request always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s1)
		else $error("accepted request lost at stage 1");

	// clamped position never exceeds one
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (t_s4 <= lgpc_pkg::T_W'(lgpc_pkg::T_ONE)))
		else $error("position above 1.0");

	// stop-local position never exceeds one
	a_tt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (tt_s5 <= lgpc_pkg::T_W'(lgpc_pkg::T_ONE)))
		else $error("stop position above 1.0");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of linear_gradient_pixel_color
// Drives pixel coordinates through the fill block under bursty requests and
// a stalling output, and checks every returned RGB565 color against a
// known table color or an in-bench gradient predictor. A directed table runs
// first, then randomly configured phases of free and raster-ordered pixels.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// frame geometry seen by the predictor
	localparam int     FRAME_W = 320;
	localparam int     FRAME_H = 240;
	// sqrt(320^2 + 240^2) is exactly 400, so the Q.8 diagonal is 400 * 256
	localparam longint DIAG_Q8 = 102400;
	localparam longint ONE_T   = 65536;
	localparam longint HALF_T  = 32768;

	localparam int PIPE_DEPTH      = 6;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int REPORT_LIMIT    = 10;

	// what a directed row does to the registers before its pixel
	localparam logic [1:0] ROW_KEEP   = 2'd0;
	localparam logic [1:0] ROW_ALL    = 2'd1;
	localparam logic [1:0] ROW_COLORS = 2'd2;

	typedef struct packed {
		logic [1:0]           setup;
		lgpc_pkg::fill_mode_t mode;
		logic                 three;
		logic [15:0]          solid;
		logic [15:0]          stop0;
		logic [15:0]          stop1;
		logic [15:0]          stop2;
		logic signed [15:0]   dir_x;
		logic signed [15:0]   dir_y;
		logic [8:0]           px;
		logic [7:0]           py;
		logic                 known;
		logic [15:0]          color;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 25;

	// setup, mode, three, solid, stop0..2, dir x/y, pixel x/y, known, color
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		// reset state: solid black
		'{ROW_KEEP, lgpc_pkg::MODE_SOLID, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd0, 1'b1, 16'h0000},
		'{ROW_KEEP, lgpc_pkg::MODE_SOLID, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd511, 8'd255, 1'b1, 16'h0000},
		// diagonal along the reset direction (+x)
		'{ROW_COLORS, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
		  16'sd0, 16'sd0, 9'd511, 8'd0, 1'b1, 16'hFFFF},
		'{ROW_KEEP, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd160, 8'd100, 1'b0, 16'h0000},
		// solid colors
		'{ROW_ALL, lgpc_pkg::MODE_SOLID, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd319, 8'd239, 1'b1, 16'hFFFF},
		'{ROW_ALL, lgpc_pkg::MODE_SOLID, 1'b1, 16'hA5C3, 16'h1111, 16'h2222, 16'h3333,
		  16'sd5, 16'sd7, 9'd77, 8'd33, 1'b1, 16'hA5C3},
		// vertical, two stops, incl. rows beyond the frame
		'{ROW_ALL, lgpc_pkg::MODE_VERT, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd0, 1'b1, 16'h0000},
		'{ROW_KEEP, lgpc_pkg::MODE_VERT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd5, 8'd240, 1'b1, 16'hFFFF},
		'{ROW_KEEP, lgpc_pkg::MODE_VERT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd9, 8'd255, 1'b1, 16'hFFFF},
		'{ROW_KEEP, lgpc_pkg::MODE_VERT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd300, 8'd239, 1'b0, 16'h0000},
		// horizontal, decreasing red, increasing blue, columns beyond the frame
		'{ROW_ALL, lgpc_pkg::MODE_HORIZ, 1'b0, 16'h0000, 16'hF800, 16'h001F, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd17, 1'b1, 16'hF800},
		'{ROW_KEEP, lgpc_pkg::MODE_HORIZ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd320, 8'd0, 1'b1, 16'h001F},
		'{ROW_KEEP, lgpc_pkg::MODE_HORIZ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd511, 8'd255, 1'b1, 16'h001F},
		'{ROW_KEEP, lgpc_pkg::MODE_HORIZ, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd160, 8'd120, 1'b0, 16'h0000},
		// vertical, three stops around the split at one half
		'{ROW_ALL, lgpc_pkg::MODE_VERT, 1'b1, 16'h0000, 16'h0000, 16'h07E0, 16'hF81F,
		  16'sd0, 16'sd0, 9'd0, 8'd0, 1'b1, 16'h0000},
		'{ROW_KEEP, lgpc_pkg::MODE_VERT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd120, 1'b1, 16'h07E0},
		'{ROW_KEEP, lgpc_pkg::MODE_VERT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd119, 1'b0, 16'h0000},
		'{ROW_KEEP, lgpc_pkg::MODE_VERT, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd255, 1'b1, 16'hF81F},
		// diagonal: origin, negative projection, oversized and mixed-sign directions
		'{ROW_ALL, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h1234, 16'hFEDC, 16'h0000,
		  16'sd16384, 16'sd0, 9'd0, 8'd0, 1'b1, 16'h1234},
		'{ROW_ALL, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h1234, 16'hFEDC, 16'h0000,
		  -16'sd16384, -16'sd16384, 9'd100, 8'd100, 1'b1, 16'h1234},
		'{ROW_ALL, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h1234, 16'hFEDC, 16'h0000,
		  16'sd32767, 16'sd32767, 9'd511, 8'd255, 1'b1, 16'hFEDC},
		'{ROW_ALL, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h1234, 16'hFEDC, 16'h0000,
		  16'sh8000, 16'sd32767, 9'd0, 8'd255, 1'b0, 16'h0000},
		'{ROW_ALL, lgpc_pkg::MODE_DIAG, 1'b0, 16'h0000, 16'h1234, 16'hFEDC, 16'h0000,
		  16'sd11585, 16'sd11585, 9'd200, 8'd150, 1'b0, 16'h0000},
		// diagonal with three stops, saturated and at the origin
		'{ROW_ALL, lgpc_pkg::MODE_DIAG, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'h8410,
		  16'sd16384, 16'sd0, 9'd511, 8'd0, 1'b1, 16'h8410},
		'{ROW_KEEP, lgpc_pkg::MODE_DIAG, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		  16'sd0, 16'sd0, 9'd0, 8'd0, 1'b1, 16'h0000}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [lgpc_pkg::PX_W-1:0]       pixel_x;
	logic [lgpc_pkg::PY_W-1:0]       pixel_y;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [lgpc_pkg::COLOR_W-1:0]    pixel_color;
	logic                            cfg_we;
	logic [lgpc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lgpc_pkg::CFG_DATA_W-1:0] cfg_data;

	// shadow copy of the configuration registers
	lgpc_pkg::fill_mode_t shadow_mode;
	logic                 shadow_three;
	logic [15:0]          shadow_solid;
	logic [15:0]          shadow_stop [3];
	logic signed [15:0]   shadow_dir_x;
	logic signed [15:0]   shadow_dir_y;

	logic [15:0] expected_colors [$];
	logic [15:0] oldest_color;

	int cycle_count;
	int mismatch_count;
	int pixels_sent;
	int colors_checked;
	int burst_left;
	int gap_style;
	int stall_style;
	int stall_run_left = 0;

	linear_gradient_pixel_color dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_color (pixel_color),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors still outstanding",
				cycle_count, expected_colors.size());
			$display("tb failed");
			$finish;
		end
	end

	// one 5/6/5 channel: start + t * (end - start), floored
	function automatic int blend_channel(input int a, input int b, input longint t);
		longint num;
		num = longint'(a) * ONE_T + t * (b - a);
		if (num < 0)
			num = 0;
		return int'(num >>> 16);
	endfunction

	function automatic logic [15:0] blend_rgb565(input logic [15:0] c0, input logic [15:0] c1,
			input longint t);
		int r;
		int g;
		int b;
		r = blend_channel(int'(c0[15:11]), int'(c1[15:11]), t);
		g = blend_channel(int'(c0[10:5]), int'(c1[10:5]), t);
		b = blend_channel(int'(c0[4:0]), int'(c1[4:0]), t);
		return {r[4:0], g[5:0], b[4:0]};
	endfunction

	// gradient position in Q0.16, clamped to 1.0
	function automatic longint gradient_position(input logic [8:0] px, input logic [7:0] py);
		longint proj;
		longint t;
		case (shadow_mode)
			lgpc_pkg::MODE_VERT:  t = (longint'(py) << 16) / FRAME_H;
			lgpc_pkg::MODE_HORIZ: t = (longint'(px) << 16) / FRAME_W;
			default: begin
				proj = longint'(px) * longint'(shadow_dir_x) + longint'(py) * longint'(shadow_dir_y);
				if (proj <= 0)
					t = 0;
				else
					t = (proj <<< 10) / DIAG_Q8;
			end
		endcase
		if (t > ONE_T)
			t = ONE_T;
		return t;
	endfunction

	function automatic logic [15:0] gradient_color(input logic [8:0] px, input logic [7:0] py);
		longint t;
		if (shadow_mode == lgpc_pkg::MODE_SOLID)
			return shadow_solid;
		t = gradient_position(px, py);
		if (!shadow_three)
			return blend_rgb565(shadow_stop[0], shadow_stop[1], t);
		if (t < HALF_T)
			return blend_rgb565(shadow_stop[0], shadow_stop[1], t * 2);
		return blend_rgb565(shadow_stop[1], shadow_stop[2], (t - HALF_T) * 2);
	endfunction

	// register write, mirrored into the shadow copy
	task automatic write_register(input lgpc_pkg::cfg_reg_t idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			lgpc_pkg::REG_FILL_MODE:   shadow_mode  = lgpc_pkg::fill_mode_t'(data[1:0]);
			lgpc_pkg::REG_THREE_STOPS: shadow_three = data[0];
			lgpc_pkg::REG_SOLID_COLOR: shadow_solid = data;
			lgpc_pkg::REG_STOP_0:      shadow_stop[0] = data;
			lgpc_pkg::REG_STOP_1:      shadow_stop[1] = data;
			lgpc_pkg::REG_STOP_2:      shadow_stop[2] = data;
			lgpc_pkg::REG_DIR_X:       shadow_dir_x = data;
			lgpc_pkg::REG_DIR_Y:       shadow_dir_y = data;
		endcase
		@(posedge clk);
	endtask

	// one pixel request, sent inside a burst or after a random gap
	task automatic push_pixel(input logic [8:0] px, input logic [7:0] py, input logic known,
			input logic [15:0] known_color);
		logic [15:0] color;
		int          gap;
		color = known ? known_color : gradient_color(px, py);
		if (burst_left == 0) begin
			gap = (gap_style == 0) ? 0 : $urandom_range(1, (gap_style == 1) ? 3 : 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		pixel_x  <= px;
		pixel_y  <= py;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		expected_colors.push_back(color);
		pixels_sent++;
		burst_left--;
	endtask

	// let the pipeline empty before touching the registers
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic apply_row_setup(input directed_row_t row);
		write_register(lgpc_pkg::REG_FILL_MODE, {14'd0, row.mode});
		write_register(lgpc_pkg::REG_THREE_STOPS, {15'd0, row.three});
		write_register(lgpc_pkg::REG_SOLID_COLOR, row.solid);
		write_register(lgpc_pkg::REG_STOP_0, row.stop0);
		write_register(lgpc_pkg::REG_STOP_1, row.stop1);
		write_register(lgpc_pkg::REG_STOP_2, row.stop2);
		if (row.setup == ROW_ALL) begin
			write_register(lgpc_pkg::REG_DIR_X, row.dir_x);
			write_register(lgpc_pkg::REG_DIR_Y, row.dir_y);
		end
		cfg_we <= 1'b0;
	endtask

	// random register contents; early phases write everything and walk the modes
	task automatic setup_random_phase(input int phase);
		logic [15:0]        data;
		int                 pick;
		lgpc_pkg::cfg_reg_t idx;
		for (int r = 0; r < 8; r++) begin
			idx = lgpc_pkg::cfg_reg_t'(r);
			if (phase >= 4 && $urandom_range(0, 3) == 0)
				continue;
			data = 16'($urandom);
			pick = $urandom_range(0, 7);
			case (idx)
				lgpc_pkg::REG_FILL_MODE: begin
					if (phase < 4)
						data[1:0] = phase[1:0];
				end
				lgpc_pkg::REG_THREE_STOPS: ;
				lgpc_pkg::REG_DIR_X, lgpc_pkg::REG_DIR_Y: begin
					if (pick <= 4)
						data = 16'($urandom_range(0, 32768) - 16384);
					else if (pick == 6)
						data = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
					else if (pick == 7)
						data = 16'h0000;
				end
				default: begin
					if (pick == 0)
						data = 16'h0000;
					else if (pick == 1)
						data = 16'hFFFF;
				end
			endcase
			write_register(idx, data);
		end
		cfg_we <= 1'b0;
	endtask

	// free pixels, with a few beyond the frame, or a raster walk
	task automatic run_random_phase();
		logic raster;
		int   scan_x;
		int   scan_y;
		raster = ($urandom_range(0, 2) == 0);
		scan_x = $urandom_range(0, FRAME_W - 1);
		scan_y = $urandom_range(0, FRAME_H - 1);
		for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
			if (raster) begin
				push_pixel(9'(scan_x), 8'(scan_y), 1'b0, 16'h0000);
				scan_x++;
				if (scan_x == FRAME_W) begin
					scan_x = 0;
					scan_y = (scan_y + 1) % FRAME_H;
				end
			end else if ($urandom_range(0, 7) == 0) begin
				push_pixel(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
					1'b0, 16'h0000);
			end else begin
				push_pixel(9'($urandom_range(0, FRAME_W - 1)),
					8'($urandom_range(0, FRAME_H - 1)), 1'b0, 16'h0000);
			end
		end
	endtask

	// output side: check each color and stall on a pattern of its own
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_colors.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected pixel color %h", pixel_color);
			end else begin
				oldest_color = expected_colors.pop_front();
				colors_checked++;
				if (pixel_color !== oldest_color) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("color mismatch on result %0d: expected %h, got %h",
							colors_checked, oldest_color, pixel_color);
				end
			end
		end
		if (stall_run_left == 0) begin
			if (stall_style == 0) begin
				out_stall <= 1'b0;
				stall_run_left <= 8;
			end else begin
				out_stall <= (stall_style == 1) ? ($urandom_range(0, 3) == 0)
					: ($urandom_range(0, 1) == 0);
				stall_run_left <= $urandom_range(1, (stall_style == 1) ? 4 : 15);
			end
		end else begin
			stall_run_left <= stall_run_left - 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		pixel_x        = '0;
		pixel_y        = '0;
		cfg_we         = 1'b0;
		cfg_index      = lgpc_pkg::REG_FILL_MODE;
		cfg_data       = '0;
		cycle_count    = 0;
		mismatch_count = 0;
		pixels_sent    = 0;
		colors_checked = 0;
		burst_left     = 0;
		gap_style      = 1;
		stall_style    = 1;
		// register defaults: solid black, two stops, direction +x (1.0 in Q1.14)
		shadow_mode    = lgpc_pkg::MODE_SOLID;
		shadow_three   = 1'b0;
		shadow_solid   = 16'h0000;
		shadow_stop[0] = 16'h0000;
		shadow_stop[1] = 16'h0000;
		shadow_stop[2] = 16'h0000;
		shadow_dir_x   = 16'sd16384;
		shadow_dir_y   = 16'sd0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].setup != ROW_KEEP) begin
				wait_drained();
				apply_row_setup(directed_rows[i]);
			end
			push_pixel(directed_rows[i].px, directed_rows[i].py, directed_rows[i].known,
				directed_rows[i].color);
		end

		// random phases, each with its own idling style
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			setup_random_phase(phase);
			gap_style   = $urandom_range(0, 2);
			stall_style = $urandom_range(0, 2);
			run_random_phase();
		end

		wait_drained();
		mismatch_count += expected_colors.size();
		$display("sent %0d pixels (%0d directed rows, %0d random phases), checked %0d colors",
			pixels_sent, DIRECTED_ROWS, RANDOM_PHASES, colors_checked);
		$display("all four fill modes with two and three stops, %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
